### rtl/core/multi_channel_oneshot_timer_defines.svh
// Assertion macros shared by the timer bank RTL.
// No dependencies; included by mcot_seq, and the top module uses its macros too.
`ifndef MULTI_CHANNEL_ONESHOT_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_ONESHOT_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked under reset disable.
`define MCOT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define MCOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCOT_ASSERT(lbl, clk, rstn, prop, msg)
`define MCOT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/mcot_pkg.sv
// Types and constants of the one-shot timer bank.
// No dependencies.
package mcot_pkg;

    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 2;
    localparam int TARGET_W  = 16;
    localparam int MASK_W    = 4;
    localparam int IDX_MAX_W = 5;   // enough for 32 channels

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_INIT  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic                 sweep;  // update channel idx with the shared unit
        logic                 exec;   // apply start or init to the addressed channel
        logic [IDX_MAX_W-1:0] idx;
    } t_ctl;

endpackage

### rtl/core/mcot_in_if.sv
// Input channel of the timer bank: command word with valid/ready.
// Depends on mcot_pkg.
interface mcot_in_if;
    logic                           valid;
    logic                           ready;
    logic [mcot_pkg::MODE_W-1:0]    mode;
    logic [mcot_pkg::CHAN_W-1:0]    channel;
    logic [mcot_pkg::TARGET_W-1:0]  target_value;

    modport source (output valid, mode, channel, target_value, input ready);
    modport sink   (input valid, mode, channel, target_value, output ready);
endinterface

### rtl/core/mcot_out_if.sv
// Output channel of the timer bank: status word with valid/ready.
// Depends on mcot_pkg.
interface mcot_out_if;
    logic                         valid;
    logic                         ready;
    logic [mcot_pkg::MASK_W-1:0]  expired_mask;
    logic [mcot_pkg::MASK_W-1:0]  running_mask;

    modport source (output valid, expired_mask, running_mask, input ready);
    modport sink   (input valid, expired_mask, running_mask, output ready);
endinterface

### rtl/core/mcot_unit.sv
// Shared per-channel tick unit: compare count to target, increment or expire.
// No package dependencies.
module mcot_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COUNT_BITS-1:0] i_target,
    input  logic                  i_running,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_running,
    output logic                  o_expire
);

    always_comb begin
        o_count   = i_count;
        o_running = i_running;
        o_expire  = 1'b0;
        if (i_running) begin
            if (i_count < i_target) begin
                o_count = i_count + COUNT_BITS'(1);
            end else begin
                o_count   = '0;
                o_running = 1'b0;
                o_expire  = 1'b1;
            end
        end
    end

endmodule

### rtl/core/mcot_seq.sv
// Sequencer: accepts one word, sweeps the channels on a tick or executes any other command, then holds the result.
// Depends on mcot_pkg and the assertion macros header.
`include "multi_channel_oneshot_timer_defines.svh"

module mcot_seq #(
    parameter int CHANNELS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [mcot_pkg::MODE_W-1:0] i_in_mode,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output mcot_pkg::t_ctl              o_ctl
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mcot_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_fire;

    assign w_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcot_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl.sweep = 1'b0;
        o_ctl.exec  = 1'b0;
        o_ctl.idx   = mcot_pkg::IDX_MAX_W'(r_idx);
        unique case (r_state)
            mcot_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_fire) begin
                    n_idx = '0;
                    if (i_in_mode == mcot_pkg::MODE_TICK) begin
                        n_state = mcot_pkg::ST_SWEEP;
                    end else begin
                        n_state = mcot_pkg::ST_EXEC;
                    end
                end
            end
            mcot_pkg::ST_SWEEP: begin
                o_ctl.sweep = 1'b1;
                if (r_idx == IDX_W'(CHANNELS - 1)) begin
                    n_state = mcot_pkg::ST_RESP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            mcot_pkg::ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = mcot_pkg::ST_RESP;
            end
            mcot_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = mcot_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcot_pkg::ST_IDLE;
            end
        endcase
    end

    `MCOT_ASSERT_ALWAYS(a_ready_xor_result, i_clk, !(o_in_ready && o_out_valid), "ready while result pending")
    `MCOT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_fire |=> !o_in_ready, "ready right after accept")
    `MCOT_ASSERT(a_sweep_in_range, i_clk, i_rst_n, o_ctl.sweep |-> (32'(r_idx) < CHANNELS), "sweep index past last channel")
    `MCOT_ASSERT(a_sweep_to_resp, i_clk, i_rst_n, (o_ctl.sweep && (32'(r_idx) == CHANNELS - 1)) |=> o_out_valid, "sweep did not end in result")

endmodule

### rtl/core/multi_channel_oneshot_timer.sv
// Bank of one-shot delay timers: channel storage, shared tick unit, sequencer.
// Depends on mcot_pkg, mcot_in_if, mcot_out_if, mcot_unit, mcot_seq.
//
// Usage:
//   i_in carries command words: mode tick (advance every running channel),
//   start (re-arm channel: clear expired, set running, keep count) and
//   init (load target, clear count). o_out returns one status word per
//   command with the expired and running masks after the update.
//   Timing: a tick is swept through the shared compare/increment unit one
//   channel per cycle in ST_SWEEP before the result is offered in ST_RESP;
//   start, init and unused modes pass through ST_EXEC to ST_RESP. Once the
//   result is taken the sequencer returns to ST_IDLE and takes a new word.
//   One word is worked on at a time; i_in.ready is low from accept until
//   the result is taken.
//   Reset: every channel running, counts, targets and expired flags zero.
//   A stalled receiver holds the result word stable and keeps i_in.ready low.
//   Start or init on a channel at or above CHANNELS changes nothing.
module multi_channel_oneshot_timer #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcot_in_if.sink    i_in,
    mcot_out_if.source o_out
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [COUNT_BITS-1:0] r_count  [CHANNELS];
    logic [COUNT_BITS-1:0] r_target [CHANNELS];
    logic [CHANNELS-1:0]   r_running;
    logic [CHANNELS-1:0]   r_expired;

    logic [mcot_pkg::MODE_W-1:0] r_mode;
    logic [mcot_pkg::CHAN_W-1:0] r_chan;
    logic [COUNT_BITS-1:0]       r_tgt;

    mcot_pkg::t_ctl        w_ctl;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_chan_idx;
    logic                  w_chan_ok;
    logic [COUNT_BITS-1:0] w_u_count;
    logic                  w_u_running;
    logic                  w_u_expire;

    mcot_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctl       (w_ctl)
    );

    assign w_idx      = w_ctl.idx[IDX_W-1:0];
    assign w_chan_idx = IDX_W'(r_chan);
    assign w_chan_ok  = (32'(r_chan) < CHANNELS);

    mcot_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .i_count   (r_count[w_idx]),
        .i_target  (r_target[w_idx]),
        .i_running (r_running[w_idx]),
        .o_count   (w_u_count),
        .o_running (w_u_running),
        .o_expire  (w_u_expire)
    );

    // command word capture
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode <= i_in.mode;
            r_chan <= i_in.channel;
            r_tgt  <= COUNT_BITS'(i_in.target_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c]  <= '0;
                r_target[c] <= '0;
            end
            r_running <= '1;
            r_expired <= '0;
        end else if (w_ctl.sweep) begin
            r_count[w_idx]   <= w_u_count;
            r_running[w_idx] <= w_u_running;
            if (w_u_expire) begin
                r_expired[w_idx] <= 1'b1;
            end
        end else if (w_ctl.exec && w_chan_ok) begin
            unique case (r_mode)
                mcot_pkg::MODE_START: begin
                    r_running[w_chan_idx] <= 1'b1;
                    r_expired[w_chan_idx] <= 1'b0;
                end
                mcot_pkg::MODE_INIT: begin
                    r_count[w_chan_idx]  <= '0;
                    r_target[w_chan_idx] <= r_tgt;
                end
                default: begin
                end
            endcase
        end
    end

    // masks show channels 0..3 only
    for (genvar g = 0; g < mcot_pkg::MASK_W; g++) begin : g_mask
        if (g < CHANNELS) begin : g_on
            assign o_out.expired_mask[g] = r_expired[g];
            assign o_out.running_mask[g] = r_running[g];
        end else begin : g_off
            assign o_out.expired_mask[g] = 1'b0;
            assign o_out.running_mask[g] = 1'b0;
        end
    end

    `MCOT_ASSERT(a_run_excl_exp, i_clk, i_rst_n, (r_running & r_expired) == '0, "channel running and expired")
    `MCOT_ASSERT(a_result_stable, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> $stable(r_running) && $stable(r_expired), "flags moved under stall")
    `MCOT_ASSERT(a_idle_no_write, i_clk, i_rst_n, i_in.ready |=> $stable(r_running) && $stable(r_expired), "flags moved while idle")

endmodule
